>>> sv/bprm_pkg.sv
`default_nettype none

package bprm_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MAX_BLOCK_DEF   = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // configuration register file
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned CFG_W     = LEN_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_METER_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'd1;

  localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST = 13'd1024;

  // finished blocks waiting between accumulator and divide/sqrt unit
  localparam int unsigned QUEUE_DEPTH = 2;

  // back-end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } bk_state_e;

endpackage

`default_nettype wire

>>> sv/block_peak_rms_meter.sv
// Block peak and rms meter. Signed samples (Q1.23 at the default width) enter
// through a queue-style port: one item is taken at every edge with push high
// and full low, so samples stream one per cycle. Every block_length items
// (zero counts as one, values above MAX_BLOCK clip to MAX_BLOCK) the meter
// emits the block's peak magnitude and floor(sqrt(floor(sum of squares /
// length))), then restarts its accumulators; with meter_enable low, items are
// taken and dropped. The accumulator is a three-stage pipeline (magnitude,
// square, sum) that hands each finished block to a two-entry queue. A serial
// back end works through one queued block at a time: a restoring divider
// giving one quotient bit per cycle, then a square root giving one root bit
// per cycle (SUM_W = 59 at the defaults). Blocks of 91 items or more never
// stall the input while results are taken as they appear; with shorter
// blocks, or with results left waiting, full rises once two finished blocks
// (queued or still in the pipeline) wait behind the one being computed. The
// result stays on the output ports while empty is low, until taken with pop.
// Configuration writes are taken at once and should be made while the meter
// is idle.
`default_nettype none

module block_peak_rms_meter #(
  parameter int unsigned MAX_BLOCK   = bprm_pkg::MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = bprm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bprm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bprm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic signed [SAMPLE_BITS-1:0]  sample_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [SAMPLE_BITS-1:0]         peak_level_o,
  output logic [SAMPLE_BITS-1:0]         rms_level_o
);
  import bprm_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SUM_W = 2 * SB - 1 + $clog2(MAX_BLOCK);
  localparam int unsigned EL_W  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned ENT_W = EL_W + SB + SUM_W;
  localparam int unsigned QC_W  = $clog2(QUEUE_DEPTH + 1);

  logic             ent_push;
  logic [SUM_W-1:0] ent_sum;
  logic [SB-1:0]    ent_peak;
  logic [EL_W-1:0]  ent_len;
  logic [ENT_W-1:0] q_rdata;
  logic             q_empty, q_pop;
  logic [QC_W-1:0]  q_count;

  // accumulator front end
  bprm_front #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .EL_W        (EL_W),
    .QC_W        (QC_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .q_count_i   (q_count),
    .ent_push_o  (ent_push),
    .ent_sum_o   (ent_sum),
    .ent_peak_o  (ent_peak),
    .ent_len_o   (ent_len)
  );

  // finished blocks
  bprm_fifo #(
    .W     (ENT_W),
    .DEPTH (QUEUE_DEPTH),
    .QC_W  (QC_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ent_push),
    .wdata_i ({ent_len, ent_peak, ent_sum}),
    .rd_i    (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  // divide and square root back end
  bprm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .EL_W        (EL_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_sum_i      (q_rdata[SUM_W-1:0]),
    .q_peak_i     (q_rdata[SUM_W +: SB]),
    .q_len_i      (q_rdata[SUM_W+SB +: EL_W]),
    .pop          (pop),
    .empty        (empty),
    .peak_level_o (peak_level_o),
    .rms_level_o  (rms_level_o)
  );

endmodule

`default_nettype wire

>>> sv/bprm_front.sv
`default_nettype none

module bprm_front #(
  parameter int unsigned MAX_BLOCK   = bprm_pkg::MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = bprm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned SUM_W       = 59,
  parameter int unsigned EL_W        = 13,
  parameter int unsigned QC_W        = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bprm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bprm_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             push,
  output logic                             full,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  logic [QC_W-1:0]                  q_count_i,
  output logic                             ent_push_o,
  output logic [SUM_W-1:0]                 ent_sum_o,
  output logic [SAMPLE_BITS-1:0]           ent_peak_o,
  output logic [EL_W-1:0]                  ent_len_o
);
  import bprm_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CMP_W = (LEN_W > EL_W) ? LEN_W : EL_W;

  // configuration registers
  logic             en_q;
  logic [LEN_W-1:0] bl_q;

  // block accumulators
  logic [EL_W-1:0]  cnt_q, cnt_d;
  logic [SB-1:0]    peak_q, peak_d;
  logic [SUM_W-1:0] sum_q, sum_d;

  // magnitude stage
  logic             v1_q, close1_q;
  logic [SB-1:0]    mag1_q;
  logic [EL_W-1:0]  len1_q;

  // square stage
  logic             v2_q, close2_q;
  logic [2*SB-1:0]  sq2_q;
  logic [SB-1:0]    pk2_q;
  logic [EL_W-1:0]  len2_q;

  logic             take;
  logic [SB-1:0]    mag_c;
  logic [CMP_W-1:0] bl_ext, eff_ext;
  logic [EL_W-1:0]  eff_len;
  logic [EL_W:0]    cnt_inc;
  logic             close_c;
  logic [SB-1:0]    pk_max;
  logic [SUM_W-1:0] sum_new;
  logic [QC_W:0]    fill;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      bl_q <= BLOCK_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_METER_ENABLE: en_q <= cfg_wdata_i[0];
        REG_BLOCK_LENGTH: bl_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective block length: zero reads as one, clipped at the maximum
  always_comb begin
    bl_ext = CMP_W'(bl_q);
    if (bl_q == '0) begin
      eff_ext = CMP_W'(1);
    end else if (bl_ext > CMP_W'(MAX_BLOCK)) begin
      eff_ext = CMP_W'(MAX_BLOCK);
    end else begin
      eff_ext = bl_ext;
    end
    eff_len = eff_ext[EL_W-1:0];
  end

  // room check: queued blocks plus block ends still in the pipeline
  assign fill = (QC_W+1)'(q_count_i) + (QC_W+1)'(v1_q & close1_q)
              + (QC_W+1)'(v2_q & close2_q);
  assign full = fill >= (QC_W+1)'(QUEUE_DEPTH);
  assign take = push && !full && en_q;

  // magnitude, sample count and block end
  assign mag_c   = sample_i[SB-1] ? (~sample_i + SB'(1)) : sample_i;
  assign cnt_inc = (EL_W+1)'(cnt_q) + (EL_W+1)'(1);
  assign close_c = cnt_inc >= (EL_W+1)'(eff_len);

  always_comb begin
    cnt_d = cnt_q;
    if (take) begin
      cnt_d = close_c ? '0 : cnt_inc[EL_W-1:0];
    end
  end

  // running peak
  assign pk_max = (mag1_q > peak_q) ? mag1_q : peak_q;

  always_comb begin
    peak_d = peak_q;
    if (v1_q) begin
      peak_d = close1_q ? '0 : pk_max;
    end
  end

  // sum of squares
  assign sum_new = sum_q + SUM_W'(sq2_q);

  always_comb begin
    sum_d = sum_q;
    if (v2_q) begin
      sum_d = close2_q ? '0 : sum_new;
    end
  end

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      peak_q   <= '0;
      sum_q    <= '0;
      v1_q     <= 1'b0;
      close1_q <= 1'b0;
      v2_q     <= 1'b0;
      close2_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      peak_q   <= peak_d;
      sum_q    <= sum_d;
      v1_q     <= take;
      close1_q <= take && close_c;
      v2_q     <= v1_q;
      close2_q <= v1_q && close1_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      mag1_q <= mag_c;
      len1_q <= eff_len;
    end
    if (v1_q) begin
      sq2_q  <= (2*SB)'(mag1_q) * (2*SB)'(mag1_q);
      pk2_q  <= pk_max;
      len2_q <= len1_q;
    end
  end

  // finished block to the queue
  assign ent_push_o = v2_q && close2_q;
  assign ent_sum_o  = sum_new;
  assign ent_peak_o = pk2_q;
  assign ent_len_o  = len2_q;

endmodule

`default_nettype wire

>>> sv/bprm_fifo.sv
`default_nettype none

module bprm_fifo #(
  parameter int unsigned W     = 96,
  parameter int unsigned DEPTH = bprm_pkg::QUEUE_DEPTH,
  parameter int unsigned QC_W  = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  logic [W-1:0]    wdata_i,
  input  logic            rd_i,
  output logic [W-1:0]    rdata_o,
  output logic            empty_o,
  output logic [QC_W-1:0] count_o
);
  import bprm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]      mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [QC_W-1:0]   cnt_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (rd_i) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + QC_W'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - QC_W'(1);
      end
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

>>> sv/bprm_back.sv
`default_nettype none

module bprm_back #(
  parameter int unsigned SAMPLE_BITS = bprm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned SUM_W       = 59,
  parameter int unsigned EL_W        = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  output logic                   q_pop_o,
  input  logic [SUM_W-1:0]       q_sum_i,
  input  logic [SAMPLE_BITS-1:0] q_peak_i,
  input  logic [EL_W-1:0]        q_len_i,
  input  logic                   pop,
  output logic                   empty,
  output logic [SAMPLE_BITS-1:0] peak_level_o,
  output logic [SAMPLE_BITS-1:0] rms_level_o
);
  import bprm_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SQ_W  = SUM_W + (SUM_W % 2);
  localparam int unsigned ITER  = SQ_W / 2;
  localparam int unsigned RR_W  = ITER + 3;
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  bk_state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q;
  logic             out_v_q;

  logic [SUM_W-1:0] quot_q;
  logic [EL_W-1:0]  drem_q;
  logic [EL_W-1:0]  div_q;
  logic [SB-1:0]    hold_pk_q;
  logic [SQ_W-1:0]  val_q;
  logic [ITER-1:0]  root_q;
  logic [RR_W-1:0]  rrem_q;
  logic [SB-1:0]    out_pk_q;
  logic [SB-1:0]    out_rms_q;

  logic             last_div, last_sqrt, out_free, out_load;
  logic [EL_W:0]    drem_sh, ddiff;
  logic             dge;
  logic [SUM_W-1:0] quot_nx;
  logic [RR_W-1:0]  rrem_sh, trial;
  logic             rge;

  assign last_div  = (cnt_q == CNT_W'(SUM_W - 1));
  assign last_sqrt = (cnt_q == CNT_W'(ITER - 1));
  assign out_free  = !out_v_q || pop;

  // restoring divide step: one quotient bit per cycle
  assign drem_sh = {drem_q, quot_q[SUM_W-1]};
  assign ddiff   = drem_sh - {1'b0, div_q};
  assign dge     = drem_sh >= {1'b0, div_q};
  assign quot_nx = {quot_q[SUM_W-2:0], dge};

  // square root step: one root bit per cycle from two radicand bits
  assign rrem_sh = {rrem_q[RR_W-3:0], val_q[SQ_W-1 -: 2]};
  assign trial   = RR_W'({root_q, 2'b01});
  assign rge     = rrem_sh >= trial;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!q_empty_i) state_d = BK_DIV;
      BK_DIV:  if (last_div)   state_d = BK_SQRT;
      BK_SQRT: if (last_sqrt)  state_d = BK_DONE;
      BK_DONE: if (out_free)   state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: q_pop_o  = !q_empty_i;
      BK_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_DIV) begin
        cnt_q <= last_div ? '0 : cnt_q + CNT_W'(1);
      end else if (state_q == BK_SQRT) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // divide and square root datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (q_pop_o) begin
          quot_q    <= q_sum_i;
          drem_q    <= '0;
          div_q     <= q_len_i;
          hold_pk_q <= q_peak_i;
        end
      end
      BK_DIV: begin
        quot_q <= quot_nx;
        drem_q <= dge ? ddiff[EL_W-1:0] : drem_sh[EL_W-1:0];
        if (last_div) begin
          val_q  <= SQ_W'(quot_nx);
          root_q <= '0;
          rrem_q <= '0;
        end
      end
      BK_SQRT: begin
        val_q  <= val_q << 2;
        root_q <= {root_q[ITER-2:0], rge};
        rrem_q <= rge ? (rrem_sh - trial) : rrem_sh;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pk_q  <= hold_pk_q;
      out_rms_q <= root_q[SB-1:0];
    end
  end

  assign empty        = !out_v_q;
  assign peak_level_o = out_pk_q;
  assign rms_level_o  = out_rms_q;

endmodule

`default_nettype wire

>>> sv/bprm_checker.sv
`default_nettype none

module bprm_checker #(
  parameter int unsigned SAMPLE_BITS = bprm_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   empty,
  input logic                   pop,
  input logic [SAMPLE_BITS-1:0] peak_level_o,
  input logic [SAMPLE_BITS-1:0] rms_level_o
);
  import bprm_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] FullScale = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // nothing to deliver once reset has been seen
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(peak_level_o) && $stable(rms_level_o)))
    else $error("waiting result changed or vanished");

  // peak magnitude bounded by full scale
  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (peak_level_o <= FullScale))
    else $error("peak above full scale");

endmodule

bind block_peak_rms_meter bprm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bprm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .peak_level_o (peak_level_o),
  .rms_level_o  (rms_level_o)
);

`default_nettype wire

>>> tb/block_peak_rms_meter_tb.sv
`timescale 1ns / 100ps

module block_peak_rms_meter_tb;
  import bprm_pkg::*;

  localparam int unsigned SBITS        = SAMPLE_BITS_DEF;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          RANDOM_ITEMS = 480;
  localparam int          CALM_AFTER   = 360;
  localparam int          LONG_ITEMS   = 160;

  typedef logic signed [SBITS-1:0] sample_t;

  typedef struct packed {
    logic [SBITS-1:0] peak;
    logic [SBITS-1:0] rms;
  } levels_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SBITS-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SBITS-1){1'b1}}};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 push        = 1'b0;
  logic                 full;
  sample_t              sample_i    = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic [SBITS-1:0]     peak_level_o;
  logic [SBITS-1:0]     rms_level_o;

  block_peak_rms_meter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .empty       (empty),
    .pop         (pop),
    .peak_level_o(peak_level_o),
    .rms_level_o (rms_level_o)
  );

  // mirrored registers and block accumulators of the meter
  logic             meter_on   = 1'b0;
  logic [LEN_W-1:0] len_reg    = BLOCK_LENGTH_RST;
  logic [LEN_W-1:0] blk_count  = '0;
  longint unsigned  blk_peak   = 0;
  longint unsigned  blk_sumsq  = 0;

  sample_t sample_q[$];
  levels_t level_q[$];
  int      n_queued   = 0;
  int      n_accepted = 0;
  int      n_errors   = 0;
  int      gap_cnt    = 0;
  int      stall_cnt  = 0;
  int      cycles     = 0;
  bit      idle_en    = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor of the square root, one root bit per pass
  function automatic logic [31:0] root_floor(input longint unsigned v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= v) root = trial;
    end
    return root;
  endfunction

  // accumulate one sample, queue the levels when the block closes
  function automatic void meter_take(input sample_t s);
    logic [SBITS-1:0] raw;
    longint unsigned  mag;
    longint unsigned  sq;
    longint unsigned  eff;
    levels_t          lv;
    if (!meter_on) return;
    raw = s;
    mag = raw[SBITS-1] ? (64'd1 << SBITS) - {40'd0, raw} : {40'd0, raw};
    if (mag > blk_peak) blk_peak = mag;
    sq = mag * mag;
    if (blk_sumsq > ~64'd0 - sq) blk_sumsq = ~64'd0;
    else blk_sumsq = blk_sumsq + sq;
    if (len_reg == 0) eff = 1;
    else if (len_reg > MAX_BLOCK_DEF) eff = MAX_BLOCK_DEF;
    else eff = len_reg;
    blk_count = blk_count + 1'b1;
    if (blk_count >= eff || blk_count == 0) begin
      lv.peak = blk_peak[SBITS-1:0];
      lv.rms  = SBITS'(root_floor(blk_sumsq / eff));
      level_q.push_back(lv);
      blk_count = '0;
      blk_peak  = 0;
      blk_sumsq = 0;
    end
  endfunction

  // driver: feeds queued samples, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      sample_i <= '0;
      gap_cnt  <= 0;
    end else begin
      if (push && !full) begin
        meter_take(sample_i);
        n_accepted++;
      end
      if (push && full) begin
        // item stays on the port until taken
      end else if (gap_cnt != 0) begin
        push    <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (sample_q.size() != 0 && idle_en && $urandom_range(0, 5) == 0) begin
        push    <= 1'b0;
        gap_cnt <= $urandom_range(0, 4);
      end else if (sample_q.size() != 0) begin
        push     <= 1'b1;
        sample_i <= sample_q.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: takes results with random stalls and checks them
  always @(posedge clk_i or negedge rst_ni) begin
    levels_t want;
    if (!rst_ni) begin
      pop       <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (pop && !empty) begin
        if (level_q.size() == 0) begin
          $error("unexpected result: peak_level %0d rms_level %0d", peak_level_o,
                 rms_level_o);
          n_errors++;
        end else begin
          want = level_q.pop_front();
          if (peak_level_o !== want.peak) begin
            $error("peak_level: expected %0d, got %0d", want.peak, peak_level_o);
            n_errors++;
          end
          if (rms_level_o !== want.rms) begin
            $error("rms_level: expected %0d, got %0d", want.rms, rms_level_o);
            n_errors++;
          end
        end
      end
      if (stall_cnt != 0) begin
        pop       <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        pop       <= 1'b0;
        stall_cnt <= $urandom_range(0, 4);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("block_peak_rms_meter verification failed");
      $finish;
    end
  end

  task automatic feed(input sample_t s);
    sample_q.push_back(s);
    n_queued++;
  endtask

  // wait until every item is taken and every result checked
  task automatic drain(input int extra);
    while (n_accepted != n_queued || level_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_METER_ENABLE) meter_on = val[0];
    else if (idx == REG_BLOCK_LENGTH) len_reg = val;
  endtask

  // enable write with random upper data bits
  task automatic write_enable(input logic en);
    logic [CFG_W-1:0] val;
    val    = CFG_W'($urandom);
    val[0] = en;
    write_reg(REG_METER_ENABLE, val);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return sample_t'($urandom_range(0, 15)) - sample_t'(8);
      3:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] len;
    logic             en;
    int               burst;
    int               n_metered;
    int               phase;
    n_metered = 0;
    phase     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // metering off after reset: items dropped
    feed(SAMPLE_MAX);
    feed(SAMPLE_MIN);
    feed(sample_t'(12345));
    drain(DRAIN_CYCLES);

    // one-sample blocks at the extremes
    write_reg(REG_BLOCK_LENGTH, CFG_W'(1));
    write_enable(1'b1);
    feed(SAMPLE_MAX);
    feed(SAMPLE_MIN);
    feed('0);
    feed(-sample_t'(1));
    feed(sample_t'(1));
    drain(DRAIN_CYCLES);

    // zero length acts as one
    write_reg(REG_BLOCK_LENGTH, CFG_W'(0));
    feed(SAMPLE_MIN);
    feed(sample_t'(-4096));
    drain(DRAIN_CYCLES);

    // pause mid-block, dropped items, then resume
    write_reg(REG_BLOCK_LENGTH, CFG_W'(3));
    feed(sample_t'(1000));
    feed(sample_t'(-3000));
    drain(DRAIN_CYCLES);
    write_enable(1'b0);
    feed(SAMPLE_MIN);
    feed(SAMPLE_MAX);
    drain(DRAIN_CYCLES);
    write_enable(1'b1);
    feed(sample_t'(77));
    drain(DRAIN_CYCLES);

    // oversized length clips, then shortened mid-block
    write_reg(REG_BLOCK_LENGTH, {CFG_W{1'b1}});
    for (int i = 0; i < 6; i++) feed(pick_sample());
    drain(DRAIN_CYCLES);
    write_reg(REG_BLOCK_LENGTH, CFG_W'(4));
    feed(sample_t'(-5));
    drain(DRAIN_CYCLES);

    // long partial block near full scale, closed early by a length of one
    write_reg(REG_BLOCK_LENGTH, CFG_W'(MAX_BLOCK_DEF));
    for (int i = 0; i < LONG_ITEMS; i++) begin
      if ($urandom_range(0, 7) == 0) feed(pick_sample());
      else feed($urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX);
    end
    drain(DRAIN_CYCLES);
    write_reg(REG_BLOCK_LENGTH, CFG_W'(1));
    feed(SAMPLE_MIN);
    drain(DRAIN_CYCLES);

    // random phases, mostly short blocks
    while (n_metered < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       len = '0;
        1:       len = CFG_W'($urandom_range(MAX_BLOCK_DEF + 1, (1 << LEN_W) - 1));
        2, 3, 4: len = CFG_W'($urandom_range(17, 300));
        default: len = CFG_W'($urandom_range(1, 16));
      endcase
      en = ($urandom_range(0, 9) != 0);
      write_reg(REG_BLOCK_LENGTH, len);
      write_enable(en);
      if (n_metered >= CALM_AFTER) idle_en = 1'b0;
      burst = $urandom_range(1, 60);
      for (int i = 0; i < burst; i++) begin
        // sender holds off once until the meter has caught up
        if (phase == 3 && i == burst / 2) drain(0);
        feed(pick_sample());
        if (en) n_metered++;
      end
      drain(DRAIN_CYCLES);
      phase++;
    end

    drain(DRAIN_CYCLES);
    if (n_errors == 0) begin
      $display("block_peak_rms_meter verification clean");
    end else begin
      $display("block_peak_rms_meter verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bprm_pkg.sv
sv/bprm_front.sv
sv/bprm_fifo.sv
sv/bprm_back.sv
sv/block_peak_rms_meter.sv
sv/bprm_checker.sv
tb/block_peak_rms_meter_tb.sv
